@@ rtl/tlpa_pkg.sv @@
// tlpa_pkg: shared constants for the two-list pool allocator
// pool geometry, link encoding, operation and status codes; no dependencies
package tlpa_pkg;

  localparam int unsigned POOL_SIZE = 1024;
  localparam int unsigned IDX_W     = $clog2(POOL_SIZE);
  localparam int unsigned LINK_W    = $clog2(POOL_SIZE + 1);

  // null link is the value POOL_SIZE
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SIZE);

  localparam int unsigned ENTRY_W  = 10;
  localparam int unsigned STATUS_W = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ACTIVE = 2'd2;

endpackage

@@ rtl/two_list_pool_allocator.sv @@
// two_list_pool_allocator: idle/active doubly linked pool allocator, top level
// uses tlpa_pkg and two tlpa_ram instances (next links with active bit, prev links)
// an exhausted allocate or a rejected free finishes in S_W1, an allocate in S_W2 and a free
//   in S_W3, since each link memory has a single write port; busy is high from acceptance
//   until the result strobe, so a new word is not taken before the last one is done
// reset: a clearing pass over all POOL_SIZE entries rebuilds the idle chain; busy stays high
// results are shown for one cycle on done_o and cannot be stalled by the receiver
module two_list_pool_allocator
  import tlpa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic [ENTRY_W-1:0]  entry_index_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [ENTRY_W-1:0]  given_index_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_W1    = 5'b00100,
    S_W2    = 5'b01000,
    S_W3    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0]  clr_cnt_q;
  logic [LINK_W-1:0] idle_head_q, idle_head_d;
  logic [LINK_W-1:0] active_head_q, active_head_d;
  logic              func_q;
  logic [LINK_W-1:0] ent_q, ent_d;
  logic              in_range_q;
  logic [LINK_W-1:0] old_q, old_d;
  logic              done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ENTRY_W-1:0]  given_q, given_d;

  logic              accept;
  logic [IDX_W-1:0]  raddr;
  logic              nxt_we, prv_we;
  logic [IDX_W-1:0]  nxt_waddr, prv_waddr;
  logic [LINK_W:0]   nxt_wdata, nxt_rdata;
  logic [LINK_W-1:0] prv_wdata, prv_rdata;
  logic [LINK_W-1:0] nxt_link;
  logic              nxt_used;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign raddr  = (func_i == FUNC_FREE) ? IDX_W'(entry_index_i) : IDX_W'(idle_head_q);

  // next link word carries the entry's active bit on top
  tlpa_ram #(.WIDTH(LINK_W + 1), .DEPTH(POOL_SIZE)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .re_i(accept), .raddr_i(raddr), .rdata_o(nxt_rdata)
  );

  tlpa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE)) u_prev (
    .clk_i, .we_i(prv_we), .waddr_i(prv_waddr), .wdata_i(prv_wdata),
    .re_i(accept), .raddr_i(raddr), .rdata_o(prv_rdata)
  );

  assign nxt_link = nxt_rdata[LINK_W-1:0];
  assign nxt_used = nxt_rdata[LINK_W];

  always_comb begin
    state_d       = state_q;
    idle_head_d   = idle_head_q;
    active_head_d = active_head_q;
    ent_d         = ent_q;
    old_d         = old_q;
    done_d        = 1'b0;
    status_d      = status_q;
    given_d       = given_q;
    nxt_we        = 1'b0;
    nxt_waddr     = IDX_W'(ent_q);
    nxt_wdata     = {1'b0, LINK_NULL};
    prv_we        = 1'b0;
    prv_waddr     = IDX_W'(ent_q);
    prv_wdata     = LINK_NULL;

    unique case (state_q)
      S_CLEAR: begin
        nxt_we    = 1'b1;
        nxt_waddr = clr_cnt_q;
        nxt_wdata = {1'b0, LINK_W'(clr_cnt_q) + LINK_W'(1)};
        prv_we    = 1'b1;
        prv_waddr = clr_cnt_q;
        prv_wdata = (clr_cnt_q == '0) ? LINK_NULL : LINK_W'(clr_cnt_q) - LINK_W'(1);
        if (clr_cnt_q == IDX_W'(POOL_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ent_d   = (func_i == FUNC_FREE) ? LINK_W'(IDX_W'(entry_index_i)) : idle_head_q;
          state_d = S_W1;
        end
      end
      S_W1: begin
        if (func_q == FUNC_ALLOC) begin
          if (ent_q == LINK_NULL) begin
            status_d = STATUS_EMPTY;
            given_d  = '0;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            // unlink idle head, link it in front of the active list
            nxt_we        = 1'b1;
            nxt_wdata     = {1'b1, active_head_q};
            prv_we        = (nxt_link != LINK_NULL);
            prv_waddr     = IDX_W'(nxt_link);
            prv_wdata     = LINK_NULL;
            idle_head_d   = nxt_link;
            old_d         = active_head_q;
            active_head_d = ent_q;
            state_d       = S_W2;
          end
        end else begin
          if (!in_range_q || !nxt_used) begin
            status_d = STATUS_NOT_ACTIVE;
            given_d  = '0;
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            // bridge the neighbors across the freed entry, the previous one stays active
            nxt_we    = (prv_rdata != LINK_NULL);
            nxt_waddr = IDX_W'(prv_rdata);
            nxt_wdata = {1'b1, nxt_link};
            prv_we    = (nxt_link != LINK_NULL);
            prv_waddr = IDX_W'(nxt_link);
            prv_wdata = prv_rdata;
            if (active_head_q == ent_q) begin
              active_head_d = nxt_link;
            end
            state_d = S_W2;
          end
        end
      end
      S_W2: begin
        if (func_q == FUNC_ALLOC) begin
          prv_we    = (old_q != LINK_NULL);
          prv_waddr = IDX_W'(old_q);
          prv_wdata = ent_q;
          status_d  = STATUS_DONE;
          given_d   = ENTRY_W'(IDX_W'(ent_q));
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else begin
          // push freed entry on the idle head and clear its active bit
          nxt_we      = 1'b1;
          nxt_wdata   = {1'b0, idle_head_q};
          prv_we      = 1'b1;
          prv_wdata   = LINK_NULL;
          old_d       = idle_head_q;
          idle_head_d = ent_q;
          state_d     = S_W3;
        end
      end
      S_W3: begin
        prv_we    = (old_q != LINK_NULL);
        prv_waddr = IDX_W'(old_q);
        prv_wdata = ent_q;
        status_d  = STATUS_DONE;
        given_d   = '0;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_cnt_q     <= '0;
      idle_head_q   <= '0;
      active_head_q <= LINK_NULL;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      idle_head_q   <= idle_head_d;
      active_head_q <= active_head_d;
      done_q        <= done_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    old_q    <= old_d;
    status_q <= status_d;
    given_q  <= given_d;
    if (accept) begin
      func_q     <= func_i;
      in_range_q <= ({22'd0, entry_index_i} < 32'(POOL_SIZE));
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign given_index_o = given_q;

endmodule

@@ rtl/tlpa_ram.sv @@
// tlpa_ram: generic single-write, single-read synchronous ram
// read data registered, updated only when a read is enabled; no dependencies
module tlpa_ram #(
  parameter int unsigned WIDTH  = 1,
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ dv/two_list_pool_allocator_tb.sv @@
// two_list_pool_allocator_tb: self-checking bench for the idle/active list pool allocator
// drives allocate and free words with random gaps and checks status and index per word
// depends on tlpa_pkg and the two_list_pool_allocator rtl
module two_list_pool_allocator_tb
  import tlpa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    entry_t              given;
  } grant_t;

  class pool_tracker;
    link_t  next_lk [POOL_SIZE];
    link_t  prev_lk [POOL_SIZE];
    bit     in_use  [POOL_SIZE];
    link_t  idle_hd;
    link_t  active_hd;
    entry_t live [$];
    grant_t pending_grants [$];
    int unsigned errors;
    int unsigned n_words, n_alloc, n_freed, n_empty, n_reject, n_checked;

    function new();
      for (int i = 0; i < POOL_SIZE; i++) begin
        prev_lk[i] = (i == 0) ? LINK_NULL : link_t'(i - 1);
        next_lk[i] = (i + 1 < POOL_SIZE) ? link_t'(i + 1) : LINK_NULL;
        in_use[i]  = 1'b0;
      end
      idle_hd   = '0;
      active_hd = LINK_NULL;
    endfunction

    function void unlink(link_t e, bit on_active);
      link_t b;
      link_t a;
      b = prev_lk[e];
      a = next_lk[e];
      prev_lk[e] = LINK_NULL;
      next_lk[e] = LINK_NULL;
      if (b < LINK_NULL) next_lk[b] = a;
      if (a < LINK_NULL) prev_lk[a] = b;
      if (on_active) begin
        if (active_hd == e) active_hd = a;
      end else begin
        if (idle_hd == e) idle_hd = a;
      end
    endfunction

    function void push(link_t e, bit on_active);
      link_t h;
      h = on_active ? active_hd : idle_hd;
      prev_lk[e] = LINK_NULL;
      next_lk[e] = h;
      if (h < LINK_NULL) prev_lk[h] = e;
      if (on_active) active_hd = e;
      else idle_hd = e;
    endfunction

    // predict the grant for an accepted word and queue it
    function void note_word(logic f, entry_t idx);
      grant_t g;
      link_t  e;
      g.status = STATUS_DONE;
      g.given  = '0;
      n_words++;
      if (f == FUNC_ALLOC) begin
        e = idle_hd;
        if (e >= LINK_NULL) begin
          g.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          unlink(e, 1'b0);
          push(e, 1'b1);
          in_use[e] = 1'b1;
          g.given = e[ENTRY_W-1:0];
          live.push_back(e[ENTRY_W-1:0]);
          n_alloc++;
        end
      end else begin
        if (idx >= POOL_SIZE || !in_use[idx]) begin
          g.status = STATUS_NOT_ACTIVE;
          n_reject++;
        end else begin
          unlink(link_t'(idx), 1'b1);
          push(link_t'(idx), 1'b0);
          in_use[idx] = 1'b0;
          for (int i = 0; i < live.size(); i++) begin
            if (live[i] == idx) begin
              live.delete(i);
              break;
            end
          end
          n_freed++;
        end
      end
      pending_grants.push_back(g);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, entry_t given);
      grant_t g;
      n_checked++;
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected word: status %0d index %0d", $realtime, status, given);
        return;
      end
      g = pending_grants.pop_front();
      if (status !== g.status || given !== g.given) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] mismatch: expected status %0d index %0d, got status %0d index %0d",
                   $realtime, g.status, g.given, status, given);
      end
    endfunction

    function int unsigned pending();
      return pending_grants.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic                func_i        = FUNC_ALLOC;
  entry_t              entry_index_i = '0;
  logic                busy;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  entry_t              given_index_o;

  pool_tracker pool = new();

  two_list_pool_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .given_index_o (given_index_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) pool.note_word(func_i, entry_index_i);
      if (done_o) pool.check_result(status_o, given_index_o);
    end
  end

  // optional random gap, then hold the word until the block takes it
  task automatic send_word(logic f, entry_t idx, int unsigned gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start         <= 1'b1;
    func_i        <= f;
    entry_index_i <= idx;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic random_word(int unsigned alloc_pct, int unsigned gap_pct);
    entry_t idx;
    idx = entry_t'($urandom);
    if ($urandom_range(99) < alloc_pct) begin
      send_word(FUNC_ALLOC, idx, gap_pct);
    end else begin
      // mostly free a live entry from anywhere in the active list
      if (pool.live.size() != 0 && $urandom_range(99) < 80)
        idx = pool.live[$urandom_range(pool.live.size() - 1)];
      send_word(FUNC_FREE, idx, gap_pct);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reject on empty active list, middle/head/tail unlink, double free
    send_word(FUNC_FREE, '0, 0);
    send_word(FUNC_FREE, '1, 0);
    send_word(FUNC_ALLOC, '1, 0);
    send_word(FUNC_ALLOC, '0, 0);
    send_word(FUNC_ALLOC, 10'h2aa, 0);
    send_word(FUNC_FREE, 10'd1, 0);
    send_word(FUNC_FREE, 10'd1, 0);
    send_word(FUNC_FREE, 10'd2, 0);
    send_word(FUNC_FREE, 10'd0, 0);
    send_word(FUNC_ALLOC, 10'h155, 0);
    send_word(FUNC_ALLOC, '0, 0);
    send_word(FUNC_ALLOC, '0, 0);
    send_word(FUNC_ALLOC, '0, 0);
    send_word(FUNC_FREE, 10'd3, 0);
    send_word(FUNC_FREE, 10'd1023, 0);
    send_word(FUNC_FREE, 10'd0, 0);
    send_word(FUNC_ALLOC, '0, 0);
    send_word(FUNC_FREE, 10'h200, 0);

    // fill part of the pool, then overrun it, then free entries with back to back words
    repeat (650) random_word(85, 38);
    repeat (650) random_word(97, 73);
    repeat (530) random_word(20, 0);
    @(negedge clk_i);
    start <= 1'b0;

    while (pool.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d words: %0d allocated, %0d freed, %0d on an empty pool",
             pool.n_words, pool.n_alloc, pool.n_freed, pool.n_empty);
    $display("%0d frees rejected, %0d results checked, %0d errors",
             pool.n_reject, pool.n_checked, pool.errors + pool.pending());
    if (pool.errors == 0 && pool.pending() == 0) begin
      $display("two_list_pool_allocator verification clean");
    end else begin
      $display("two_list_pool_allocator verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("two_list_pool_allocator verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tlpa_pkg.sv
rtl/tlpa_ram.sv
rtl/two_list_pool_allocator.sv
dv/two_list_pool_allocator_tb.sv
